[rtl/srv_pkg.sv]
package srv_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int FW        = 20;
  localparam int N_LANE    = 3;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  localparam int FIELD_MAX = (1 << (FW - 1)) - 1;
  localparam int FIELD_MIN = -(1 << (FW - 1));

  // stream word layout
  localparam int IN_W       = 7 * FW;
  localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = N_LANE * FW;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  // dot product and r*r
  localparam int PROD_W = 2 * FW;
  localparam int DOT_W  = PROD_W + 2;
  localparam int DR_W   = DOT_W + 1 - FRAC_BITS;
  localparam int RR_W   = 2 * FW;
  localparam int R2_W   = RR_W + 1 - FRAC_BITS;

  // t = 1 - d*d
  localparam int DIFF_W = ((PROD_W > 2 * FRAC_BITS + 1) ? PROD_W : 2 * FRAC_BITS + 1) + 1;
  localparam int T_W    = DIFF_W + 1 - FRAC_BITS;

  // discriminant and root
  localparam int PRD_W  = R2_W + 1 + T_W;
  localparam int DISC_W = ((PRD_W > 2 * FRAC_BITS + 2) ? PRD_W : 2 * FRAC_BITS + 2) + 1;
  localparam int S_W    = (DISC_W + 1) / 2;
  localparam int RAD_W  = 2 * S_W;

  // tangential part w = v - n*d
  localparam int VS_W = FW + FRAC_BITS;
  localparam int WD_W = ((VS_W > PROD_W) ? VS_W : PROD_W) + 1;
  localparam int W_W  = WD_W + 1 - FRAC_BITS;

  // final combine r*w - n*s
  localparam int RW_W     = FW + 1 + W_W;
  localparam int NS_W     = FW + S_W + 1;
  localparam int OD_W     = ((RW_W > NS_W) ? RW_W : NS_W) + 1;
  localparam int O_W      = OD_W + 1 - FRAC_BITS;
  localparam int SAT_IN_W = (O_W > DR_W) ? O_W : DR_W;

  // per-ray data that rides along the square root pipeline
  typedef struct packed {
    logic                          refract;
    logic [FW-1:0]                 r;
    logic [N_LANE-1:0][FW-1:0]     n;
    logic [N_LANE-1:0][W_W-1:0]    w;
  } srv_carry_t;

  // clamp a wide signed value to the field range
  function automatic logic [FW-1:0] sat_field(input logic signed [SAT_IN_W-1:0] x);
    logic [FW-1:0] res;
    if (x > SAT_IN_W'(FIELD_MAX)) begin
      res = FW'(FIELD_MAX);
    end else if (x < SAT_IN_W'(FIELD_MIN)) begin
      res = FW'(FIELD_MIN);
    end else begin
      res = x[FW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/snell_refraction_vector.sv]
// Snell refraction of one ray direction per word. The slave word carries the
// incident direction, surface normal and index ratio in signed/unsigned fixed
// point with 16 fraction bits; the master word returns the refracted direction,
// saturated to the 20-bit range, with m_tuser[0] set when the ray refracts and
// clear (vector zero) on total internal reflection. A new word is taken every
// cycle unless the master side stalls. Five stages do the dot product, r*r,
// d*d, n*d and the discriminant product, 27 stages do the bit-per-stage square
// root, then come one multiply stage and the output register. A stall at the
// master side freezes the whole pipeline; s_tready follows it in the same cycle.
module snell_refraction_vector import srv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, index_ratio, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x, out_y, out_z, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // did_refract
  output logic [0:0]            m_tuser
);

  logic adv;

  // input unpacking
  logic signed [FW-1:0] in_v [N_LANE];
  logic signed [FW-1:0] in_n [N_LANE];
  logic [FW-1:0]        in_r;

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      in_v[i] = s_tdata[i*FW +: FW];
      in_n[i] = s_tdata[(N_LANE+i)*FW +: FW];
    end
    in_r = s_tdata[2*N_LANE*FW +: FW];
  end

  // stage registers
  logic                   p1_vld, p2_vld, p3_vld, p4_vld, p5_vld, q1_vld, out_vld;
  logic signed [PROD_W-1:0] p1_vn [N_LANE];
  logic [RR_W-1:0]        p1_rr;
  logic signed [FW-1:0]   p1_v [N_LANE];
  logic signed [FW-1:0]   p1_n [N_LANE];
  logic [FW-1:0]          p1_r;

  logic signed [FW-1:0]   p2_d;
  logic [R2_W-1:0]        p2_r2;
  logic signed [FW-1:0]   p2_v [N_LANE];
  logic signed [FW-1:0]   p2_n [N_LANE];
  logic [FW-1:0]          p2_r;

  logic signed [PROD_W-1:0] p3_dd;
  logic signed [PROD_W-1:0] p3_nd [N_LANE];
  logic [R2_W-1:0]        p3_r2;
  logic signed [FW-1:0]   p3_v [N_LANE];
  logic signed [FW-1:0]   p3_n [N_LANE];
  logic [FW-1:0]          p3_r;

  logic signed [T_W-1:0]  p4_t;
  logic [R2_W-1:0]        p4_r2;
  logic signed [W_W-1:0]  p4_w [N_LANE];
  logic signed [FW-1:0]   p4_n [N_LANE];
  logic [FW-1:0]          p4_r;

  logic signed [PRD_W-1:0] p5_prd;
  logic signed [W_W-1:0]  p5_w [N_LANE];
  logic signed [FW-1:0]   p5_n [N_LANE];
  logic [FW-1:0]          p5_r;

  logic signed [RW_W-1:0] q1_rw [N_LANE];
  logic signed [NS_W-1:0] q1_ns [N_LANE];
  logic                   q1_refract;

  logic [FW-1:0]          out_o [N_LANE];
  logic                   out_refract;

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_vld || m_tready;
  assign s_tready = adv;

  // dot product rounding and saturation, r*r rounding
  logic signed [DOT_W:0] dot_sum;
  logic signed [DOT_W:0] dot_sh;
  logic [RR_W:0]         rr_sum;

  assign dot_sum = (DOT_W+1)'(p1_vn[0]) + (DOT_W+1)'(p1_vn[1]) + (DOT_W+1)'(p1_vn[2])
                 + (DOT_W+1)'(HALF);
  assign dot_sh  = dot_sum >>> FRAC_BITS;
  assign rr_sum  = {1'b0, p1_rr} + (RR_W+1)'(HALF);

  // t = round(1 - d*d) and w = round(v - n*d)
  logic signed [DIFF_W:0] t_sum;
  logic signed [DIFF_W:0] t_sh;
  logic signed [WD_W:0]   w_sum [N_LANE];
  logic signed [WD_W:0]   w_sh  [N_LANE];

  always_comb begin
    t_sum = ((DIFF_W+1)'(1) <<< (2 * FRAC_BITS)) - (DIFF_W+1)'(p3_dd) + (DIFF_W+1)'(HALF);
    t_sh  = t_sum >>> FRAC_BITS;
    for (int i = 0; i < N_LANE; i++) begin
      w_sum[i] = ((WD_W+1)'(p3_v[i]) <<< FRAC_BITS) - (WD_W+1)'(p3_nd[i])
               + (WD_W+1)'(HALF);
      w_sh[i]  = w_sum[i] >>> FRAC_BITS;
    end
  end

  // discriminant and refract decision
  logic signed [DISC_W-1:0] disc;
  logic                     refract;
  logic [RAD_W-1:0]         rad;
  srv_carry_t               car_in;

  always_comb begin
    disc    = (DISC_W'(1) <<< (2 * FRAC_BITS)) - DISC_W'(p5_prd);
    refract = !disc[DISC_W-1] && (disc != '0);
    rad     = refract ? RAD_W'($unsigned(disc)) : '0;
    car_in.refract = refract;
    car_in.r       = p5_r;
    for (int i = 0; i < N_LANE; i++) begin
      car_in.n[i] = p5_n[i];
      car_in.w[i] = p5_w[i];
    end
  end

  // square root of the discriminant
  logic             sq_vld;
  logic [S_W-1:0]   sq_root;
  srv_carry_t       sq_car;

  srv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (p5_vld),
    .in_rad   (rad),
    .in_car   (car_in),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_car  (sq_car)
  );

  // final combine, rounding and saturation
  logic signed [OD_W:0]  o_sum [N_LANE];
  logic signed [OD_W:0]  o_sh  [N_LANE];
  logic [FW-1:0]         o_sat [N_LANE];

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      o_sum[i] = (OD_W+1)'(q1_rw[i]) - (OD_W+1)'(q1_ns[i]) + (OD_W+1)'(HALF);
      o_sh[i]  = o_sum[i] >>> FRAC_BITS;
      o_sat[i] = sat_field(SAT_IN_W'($signed(o_sh[i][O_W-1:0])));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      p3_vld  <= 1'b0;
      p4_vld  <= 1'b0;
      p5_vld  <= 1'b0;
      q1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      p1_vld  <= s_tvalid;
      p2_vld  <= p1_vld;
      p3_vld  <= p2_vld;
      p4_vld  <= p3_vld;
      p5_vld  <= p4_vld;
      q1_vld  <= sq_vld;
      out_vld <= q1_vld;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // products of the inputs
      for (int i = 0; i < N_LANE; i++) begin
        p1_vn[i] <= in_v[i] * in_n[i];
        p1_v[i]  <= in_v[i];
        p1_n[i]  <= in_n[i];
      end
      p1_rr <= in_r * in_r;
      p1_r  <= in_r;

      // d and r2
      p2_d  <= sat_field(SAT_IN_W'($signed(dot_sh[DR_W-1:0])));
      p2_r2 <= rr_sum[RR_W:FRAC_BITS];
      for (int i = 0; i < N_LANE; i++) begin
        p2_v[i] <= p1_v[i];
        p2_n[i] <= p1_n[i];
      end
      p2_r <= p1_r;

      // d*d and n*d
      p3_dd <= p2_d * p2_d;
      for (int i = 0; i < N_LANE; i++) begin
        p3_nd[i] <= p2_n[i] * p2_d;
        p3_v[i]  <= p2_v[i];
        p3_n[i]  <= p2_n[i];
      end
      p3_r2 <= p2_r2;
      p3_r  <= p2_r;

      // t and w
      p4_t  <= t_sh[T_W-1:0];
      p4_r2 <= p3_r2;
      for (int i = 0; i < N_LANE; i++) begin
        p4_w[i] <= w_sh[i][W_W-1:0];
        p4_n[i] <= p3_n[i];
      end
      p4_r <= p3_r;

      // r2*t
      p5_prd <= $signed({1'b0, p4_r2}) * p4_t;
      for (int i = 0; i < N_LANE; i++) begin
        p5_w[i] <= p4_w[i];
        p5_n[i] <= p4_n[i];
      end
      p5_r <= p4_r;

      // r*w and n*s
      for (int i = 0; i < N_LANE; i++) begin
        q1_rw[i] <= $signed({1'b0, sq_car.r}) * $signed(sq_car.w[i]);
        q1_ns[i] <= $signed(sq_car.n[i]) * $signed({1'b0, sq_root});
      end
      q1_refract <= sq_car.refract;

      // output register
      for (int i = 0; i < N_LANE; i++) begin
        out_o[i] <= q1_refract ? o_sat[i] : '0;
      end
      out_refract <= q1_refract;
    end
  end

  // master word
  assign m_tvalid = out_vld;
  assign m_tdata  = {(OUT_DATA_W-OUT_W)'(0), out_o[2], out_o[1], out_o[0]};
  assign m_tuser  = out_refract;

`ifndef SYNTHESIS
  logic [7:0] pipe_vld;
  assign pipe_vld = {p1_vld, p2_vld, p3_vld, p4_vld, p5_vld, sq_vld, q1_vld, out_vld};

  // a reflected ray leaves with a zero vector
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[OUT_W-1:0] == '0))
    else $error("total internal reflection with nonzero vector");

  // a stall freezes every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !m_tready) |=> $stable(pipe_vld))
    else $error("pipeline moved during stall");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

[rtl/srv_sqrt.sv]
module srv_sqrt import srv_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [RAD_W-1:0]    in_rad,
  input  srv_carry_t          in_car,
  output logic                out_vld,
  output logic [S_W-1:0]      out_root,
  output srv_carry_t          out_car
);

  // one root bit per stage, restoring digit recurrence
  logic [RAD_W-1:0] rad   [S_W];
  logic [S_W+1:0]   rem   [S_W];
  logic [S_W-1:0]   root  [S_W];
  logic             vld   [S_W];
  srv_carry_t       car   [S_W];

  logic [RAD_W-1:0] rad_next  [S_W];
  logic [S_W+1:0]   rem_next  [S_W];
  logic [S_W-1:0]   root_next [S_W];

  // next value of every stage from the one before it
  always_comb begin
    logic [RAD_W-1:0] rad_prev;
    logic [S_W+1:0]   rem_prev;
    logic [S_W-1:0]   root_prev;
    logic [S_W+1:0]   rem_sh;
    logic [S_W+1:0]   trial;
    logic             ge;
    for (int k = 0; k < S_W; k++) begin
      if (k == 0) begin
        rad_prev  = in_rad;
        rem_prev  = '0;
        root_prev = '0;
      end else begin
        rad_prev  = rad[k-1];
        rem_prev  = rem[k-1];
        root_prev = root[k-1];
      end
      rem_sh       = {rem_prev[S_W-1:0], rad_prev[RAD_W-1 -: 2]};
      trial        = {root_prev, 2'b01};
      ge           = (rem_sh >= trial);
      rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
      root_next[k] = {root_prev[S_W-2:0], ge};
      rad_next[k]  = {rad_prev[RAD_W-3:0], 2'b00};
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < S_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
      for (int k = 1; k < S_W; k++) vld[k] <= vld[k-1];
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      car[0] <= in_car;
      for (int k = 1; k < S_W; k++) car[k] <= car[k-1];
      for (int k = 0; k < S_W; k++) begin
        rad[k]  <= rad_next[k];
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
      end
    end
  end

  assign out_vld  = vld[S_W-1];
  assign out_root = root[S_W-1];
  assign out_car  = car[S_W-1];

`ifndef SYNTHESIS
  // a positive radicand always gives a nonzero root, a zeroed one gives zero
  a_root_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_car.refract == (out_root != '0)))
    else $error("root does not match refract flag");
`endif

endmodule

[sim/snell_refraction_vector_tb.sv]
`timescale 1ns / 100ps

module snell_refraction_vector_tb import srv_pkg::*;;

  localparam int LIMIT_CYCLES = 200000;
  localparam int STALL_CYCLES = 250;

  // one ray as it enters the block
  typedef struct {
    logic signed [FW-1:0] dir[3];
    logic signed [FW-1:0] normal[3];
    logic        [FW-1:0] ratio;
  } ray_t;

  // refracted direction as it leaves the block
  typedef struct {
    logic signed [FW-1:0] vec[3];
    logic                 refract;
  } bend_t;

  // predicts refraction per accepted ray and checks results in order
  class refraction_scoreboard;
    bend_t due[$];
    int    errors = 0;

    // add half an lsb, then floor-shift by the fraction bits
    function longint rnd_shift(longint x);
      longint y;
      y = x + (64'sd1 <<< (FRAC_BITS - 1));
      return y >>> FRAC_BITS;
    endfunction

    function longint clamp_field(longint x);
      if (x > FIELD_MAX) return FIELD_MAX;
      if (x < FIELD_MIN) return FIELD_MIN;
      return x;
    endfunction

    // bit-serial integer square root, floor
    function longint unsigned root_floor(longint unsigned x);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= res + probe) begin
          x   = x - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    function bend_t predict_bend(ray_t ray);
      longint v[3], n[3];
      longint r, one2, dsum, d, r2, t, disc, s, w, o;
      bend_t  res;
      one2 = 64'sd1 <<< (2 * FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        v[i] = ray.dir[i];
        n[i] = ray.normal[i];
      end
      r    = longint'({44'd0, ray.ratio});
      dsum = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
      d    = clamp_field(rnd_shift(dsum));
      r2   = rnd_shift(r * r);
      t    = rnd_shift(one2 - d * d);
      disc = one2 - r2 * t;
      // total internal reflection gives a zero vector
      if (disc <= 0) begin
        for (int i = 0; i < 3; i++) res.vec[i] = '0;
        res.refract = 1'b0;
        return res;
      end
      s = longint'(root_floor(longint'(disc)));
      for (int i = 0; i < 3; i++) begin
        w = rnd_shift((v[i] <<< FRAC_BITS) - n[i] * d);
        o = clamp_field(rnd_shift(r * w - n[i] * s));
        res.vec[i] = o[FW-1:0];
      end
      res.refract = 1'b1;
      return res;
    endfunction

    function void note_ray(ray_t ray);
      due.push_back(predict_bend(ray));
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void flag_mismatch(string what, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_ray(logic [OUT_DATA_W-1:0] data, logic flag);
      bend_t                exp_b;
      logic signed [FW-1:0] act;
      string                names[3];
      names = '{"out_x", "out_y", "out_z"};
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, data %h flag %b", $time, data, flag);
        return;
      end
      exp_b = due.pop_front();
      for (int i = 0; i < 3; i++) begin
        act = data[i*FW +: FW];
        if (act !== exp_b.vec[i]) flag_mismatch(names[i], exp_b.vec[i], act);
      end
      if (flag !== exp_b.refract) flag_mismatch("did_refract", exp_b.refract, flag);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  refraction_scoreboard book = new();
  bit steady    = 1'b0;
  bit stall_req = 1'b0;
  int cycles    = 0;

  snell_refraction_vector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("snell_refraction_vector test failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = STALL_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 28);
      end
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_ray(m_tdata, m_tuser[0]);
  end

  // fixed point from a real value
  function automatic int q(real x);
    return $rtoi(x * real'(1 << FRAC_BITS));
  endfunction

  function automatic ray_t mk(int dx, int dy, int dz, int nx, int ny, int nz, int r);
    ray_t ray;
    ray.dir    = '{dx[FW-1:0], dy[FW-1:0], dz[FW-1:0]};
    ray.normal = '{nx[FW-1:0], ny[FW-1:0], nz[FW-1:0]};
    ray.ratio  = r[FW-1:0];
    return ray;
  endfunction

  // random direction of unit length, with optional jitter in the low bits
  function automatic void unit_vec(output logic signed [FW-1:0] vec[3], input bit jitter);
    real a[3];
    real len;
    int  c;
    do begin
      for (int i = 0; i < 3; i++) a[i] = real'(int'($urandom_range(2000)) - 1000) / 1000.0;
      len = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    end while (len < 0.05);
    for (int i = 0; i < 3; i++) begin
      c = q(a[i] / len);
      if (jitter) c = c + int'($urandom_range(256)) - 128;
      vec[i] = c[FW-1:0];
    end
  endfunction

  function automatic ray_t random_ray();
    ray_t ray;
    int   kind;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // well-formed ray: unit vectors, ratio near 1.0 or anywhere up to 2.5
      unit_vec(ray.dir, kind >= 60);
      unit_vec(ray.normal, kind >= 60);
      if (kind < 10) ray.ratio = FW'(q(1.0) + int'($urandom_range(64)) - 32);
      else ray.ratio = FW'($urandom_range(q(2.5)));
    end else begin
      // raw bit patterns over the full field range
      for (int i = 0; i < 3; i++) begin
        ray.dir[i]    = FW'($urandom());
        ray.normal[i] = FW'($urandom());
      end
      ray.ratio = (kind < 90) ? FW'($urandom()) : FW'($urandom_range(q(2.0)));
    end
    return ray;
  endfunction

  // offer one ray, idling at random, until the block takes it
  task automatic send_ray(input ray_t ray);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({ray.ratio, ray.normal[2], ray.normal[1], ray.normal[0],
                            ray.dir[2], ray.dir[1], ray.dir[0]});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_ray(ray);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_ray(random_ray());
  endtask

  task automatic wait_drained();
    while (book.pending() != 0) @(posedge clk);
  endtask

  initial begin
    ray_t dir_list[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rays
    dir_list.push_back(mk(0, -q(1.0), 0, 0, q(1.0), 0, q(1.0)));        // straight through
    dir_list.push_back(mk(0, -q(1.0), 0, 0, q(1.0), 0, 0));             // zero ratio gives -n
    dir_list.push_back(mk(q(0.6), -q(0.8), 0, 0, q(1.0), 0, 0));
    dir_list.push_back(mk(q(0.8), -q(0.6), 0, 0, q(1.0), 0, q(2.0)));   // total reflection
    dir_list.push_back(mk(q(1.0), 0, 0, 0, q(1.0), 0, q(1.0)));         // discriminant exactly zero
    dir_list.push_back(mk(q(0.6), -q(0.8), 0, 0, q(1.0), 0, q(0.6667)));
    dir_list.push_back(mk(q(0.6), -q(0.8), 0, 0, q(1.0), 0, q(1.5)));
    dir_list.push_back(mk(0, 0, q(1.0), 0, 0, -q(1.0), 1));             // smallest ratio
    dir_list.push_back(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                          (1 << FW) - 1));
    dir_list.push_back(mk(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, 0));
    dir_list.push_back(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                          q(1.0)));
    dir_list.push_back(mk(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                          (1 << FW) - 1));
    dir_list.push_back(mk(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN,
                          q(1.0)));
    dir_list.push_back(mk(FIELD_MAX, 0, 0, 0, FIELD_MIN, 0, q(1.0)));   // discriminant zero, reflects
    dir_list.push_back(mk(FIELD_MAX, 0, 0, 0, q(1.0), 0, q(0.5)));
    dir_list.push_back(mk(0, 0, 0, 0, 0, 0, q(1.0)));                   // zero vectors, reflect
    dir_list.push_back(mk(0, 0, 0, 0, 0, 0, 0));                        // zero vectors, refract
    dir_list.push_back(mk(q(2.0), -q(3.0), q(1.5), -q(0.5), q(4.0), q(1.0), q(0.9)));
    dir_list.push_back(mk(-q(0.6), -q(0.8), 0, 0, -q(1.0), 0, q(1.33)));
    dir_list.push_back(mk(q(0.1), -q(0.995), 0, 0, q(1.0), 0, q(15.99)));
    foreach (dir_list[i]) send_ray(dir_list[i]);

    // receiver holds off while rays keep coming, so the pipeline backs up
    stall_req = 1'b1;
    send_random(500);

    // sender pauses until the pipeline is empty
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();

    // no idling on either side
    steady = 1'b1;
    send_random(400);
    steady = 1'b0;

    send_random(900);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (book.errors == 0) begin
      $display("snell_refraction_vector test passed");
    end else begin
      $display("snell_refraction_vector test failed");
    end
    $finish;
  end

endmodule
